@@ hdl/per_peer_credit_flow_control_top_defines.svh @@
// Assertion macros for the per-peer credit flow control block.
// Used by per_peer_credit_flow_control_top; no other dependencies.
`ifndef PER_PEER_CREDIT_FLOW_CONTROL_TOP_DEFINES_SVH
`define PER_PEER_CREDIT_FLOW_CONTROL_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PPCFC_ASSERT_IMPLY(label, ante, cons, text) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(text);

// Next-cycle implication, checked on every clock edge outside reset.
`define PPCFC_ASSERT_NEXT(label, ante, cons, text) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(text);

`endif

@@ hdl/ppcfc_pkg.sv @@
// Shared types and constants for the per-peer credit flow control block.
// No dependencies.
package ppcfc_pkg;

   localparam int CNT_W      = 6;
   localparam int PEER_W     = 4;
   localparam int PEER_SPAN  = 1 << PEER_W;
   localparam int PCMP_W     = 11;   // wide enough to hold any peer count
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CNT_W-1:0] CNT_MAX      = 6'd63;
   localparam logic [CNT_W-1:0] INIT_CREDITS = 6'd10;

   // Request channel action codes
   typedef enum logic [1:0] {
      ACT_SEND = 2'd0,
      ACT_MSG  = 2'd1,
      ACT_CMSG = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   // Classified command kind
   typedef enum logic [2:0] {
      KIND_SEND    = 3'd0,
      KIND_MSG     = 3'd1,
      KIND_CMSG    = 3'd2,
      KIND_REPORT  = 3'd3,   // unused action: report credits only
      KIND_NO_PEER = 3'd4    // peer outside the table: all-zero result
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [PEER_W-1:0]  idx;
      logic [CNT_W-1:0]   credits;
   } cmd_type;

endpackage

@@ hdl/per_peer_credit_flow_control_top.sv @@
// Channel  | Dir | Signals                                   | Beat contents
// req      | in  | req_tvalid/tready, req_tuser, req_tdata   | action; peer, credits_in
// rsp      | out | rsp_tvalid/tready, rsp_tdata              | status .. credits_left
// csr      | in  | csr_we, csr_wdata                         | owed threshold
//
// Sustained rate is one beat per cycle while responses are not stalled; a response
// is valid once its request beat has passed the front register, a queue slot and
// the back register. The back stage's credit table read-modify-write sets the rate.
// Reset loads every table entry at once (credits 10, owed 0); no clearing pass.
// A stalled response holds the back stage; the queue lets the front keep taking
// beats until it fills.
//
// Top level of the per-peer credit flow control block.
// Depends on ppcfc_pkg, ppcfc_front, ppcfc_queue, ppcfc_back and the defines header.
`include "per_peer_credit_flow_control_top_defines.svh"

module per_peer_credit_flow_control_top
   import ppcfc_pkg::*;
#(
   parameter int PEERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] action
   input  logic [15:0] req_tdata,   // [3:0] peer, [9:4] credits_in, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] status, [6:1] piggyback_credits,
                                    // [7] send_credit_msg, [13:8] credit_msg_count,
                                    // [19:14] credits_left, rest zero
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata
);

   logic [CNT_W-1:0] owed_limit_ff;
   logic             f_valid, f_ready, q_valid, q_ready;
   cmd_type          f_cmd, q_cmd;
   logic             rsp_refused, rsp_credit_msg;
   logic [CNT_W-1:0] rsp_piggy, rsp_msg_cnt;

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         owed_limit_ff <= INIT_CREDITS;
      end else if (csr_we) begin
         owed_limit_ff <= csr_wdata;
      end
   end

   ppcfc_front #(.PEERS(PEERS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd        (f_cmd)
   );

   ppcfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_cmd   (f_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_cmd    (q_cmd)
   );

   ppcfc_back #(.PEERS(PEERS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .owed_limit  (owed_limit_ff),
      .cmd_valid   (q_valid),
      .cmd_ready   (q_ready),
      .cmd         (q_cmd),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // Response fields seen by the checks
   assign rsp_refused    = rsp_tvalid && rsp_tdata[0];
   assign rsp_credit_msg = rsp_tvalid && rsp_tdata[7];
   assign rsp_piggy      = rsp_tdata[6:1];
   assign rsp_msg_cnt    = rsp_tdata[13:8];

   // Checks
   `PPCFC_ASSERT_IMPLY(a_refused_empty, rsp_refused, rsp_tdata[19:1] == '0, "bad refusal")
   `PPCFC_ASSERT_IMPLY(a_msg_count, rsp_credit_msg, rsp_msg_cnt != '0, "empty credit message")
   `PPCFC_ASSERT_IMPLY(a_msg_no_piggy, rsp_credit_msg, rsp_piggy == '0, "msg with piggyback")
   `PPCFC_ASSERT_NEXT(a_queue_feeds_back, q_valid && q_ready, rsp_tvalid, "no response beat")

endmodule

@@ hdl/ppcfc_front.sv @@
// Front stage: takes request beats, decodes action and range-checks the peer.
// Depends on ppcfc_pkg.
module ppcfc_front
   import ppcfc_pkg::*;
#(
   parameter int PEERS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   input  logic [15:0]          req_tdata,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output cmd_type              cmd
);

   logic       valid_ff, valid_in;
   cmd_type    cmd_ff, cmd_in;
   logic       peer_ok;
   action_type act;

   assign req_tready = !valid_ff || cmd_ready;
   assign cmd_valid  = valid_ff;
   assign cmd        = cmd_ff;

   // Decode
   always_comb begin
      act     = action_type'(req_tuser);
      peer_ok = PCMP_W'(req_tdata[PEER_W-1:0]) < PCMP_W'(PEERS);
      cmd_in.idx     = req_tdata[PEER_W-1:0];
      cmd_in.credits = req_tdata[PEER_W+CNT_W-1:PEER_W];
      if (!peer_ok) begin
         cmd_in.kind = KIND_NO_PEER;
      end else begin
         unique case (act)
            ACT_SEND: cmd_in.kind = KIND_SEND;
            ACT_MSG:  cmd_in.kind = KIND_MSG;
            ACT_CMSG: cmd_in.kind = KIND_CMSG;
            default:  cmd_in.kind = KIND_REPORT;
         endcase
      end
   end

   // Stage register
   always_comb begin
      valid_in = valid_ff;
      if (req_tready) valid_in = req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) cmd_ff <= cmd_in;
   end

endmodule

@@ hdl/ppcfc_queue.sv @@
// Short command queue between front and back stages.
// Depends on ppcfc_pkg.
module ppcfc_queue
   import ppcfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != CNT_QW'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

@@ hdl/ppcfc_back.sv @@
// Back stage: credit table read-modify-write and the response register.
// Depends on ppcfc_pkg.
module ppcfc_back
   import ppcfc_pkg::*;
#(
   parameter int PEERS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CNT_W-1:0]  owed_limit,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  cmd_type           cmd,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata
);

   localparam int DEPTH = (PEERS < PEER_SPAN) ? PEERS : PEER_SPAN;
   localparam int IDX_W = $clog2(DEPTH);

   logic [CNT_W-1:0] avail_ff [DEPTH];
   logic [CNT_W-1:0] owed_ff  [DEPTH];

   logic             rsp_valid_ff, rsp_valid_in;
   logic             status_ff, status_in;
   logic [CNT_W-1:0] piggy_ff, piggy_in;
   logic             msg_ff, msg_in;
   logic [CNT_W-1:0] msg_cnt_ff, msg_cnt_in;
   logic [CNT_W-1:0] left_ff, left_in;

   logic [IDX_W-1:0] idx;
   logic [CNT_W-1:0] av, ow, av_add, ow_inc, av_new, ow_new;
   logic [CNT_W:0]   sum;
   logic             tbl_we, do_pop;

   assign cmd_ready = !rsp_valid_ff || rsp_tready;
   assign do_pop    = cmd_valid && cmd_ready;
   assign idx       = cmd.idx[IDX_W-1:0];

   // Per-event credit arithmetic
   always_comb begin
      av     = avail_ff[idx];
      ow     = owed_ff[idx];
      sum    = {1'b0, av} + {1'b0, cmd.credits};
      av_add = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
      ow_inc = (ow == CNT_MAX) ? CNT_MAX : ow + 1'b1;

      av_new     = av;
      ow_new     = ow;
      tbl_we     = 1'b0;
      status_in  = 1'b0;
      piggy_in   = '0;
      msg_in     = 1'b0;
      msg_cnt_in = '0;
      left_in    = '0;
      unique case (cmd.kind)
         KIND_SEND: begin
            if (av == '0) begin
               status_in = 1'b1;
            end else begin
               av_new   = av - 1'b1;
               ow_new   = '0;
               piggy_in = ow;
               tbl_we   = 1'b1;
               left_in  = av - 1'b1;
            end
         end
         KIND_MSG: begin
            av_new = av_add;
            tbl_we = 1'b1;
            if (ow_inc >= owed_limit) begin
               msg_in     = 1'b1;
               msg_cnt_in = ow_inc;
               ow_new     = '0;
            end else begin
               ow_new = ow_inc;
            end
            left_in = av_add;
         end
         KIND_CMSG: begin
            av_new  = av_add;
            tbl_we  = 1'b1;
            left_in = av_add;
         end
         KIND_REPORT: left_in = av;
         default: ;   // peer out of range: zero result
      endcase
   end

   // Response handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd_ready) rsp_valid_in = cmd_valid;
   end

   // Table and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            avail_ff[i] <= INIT_CREDITS;
            owed_ff[i]  <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (do_pop && tbl_we) begin
            avail_ff[idx] <= av_new;
            owed_ff[idx]  <= ow_new;
         end
      end
      if (do_pop) begin
         status_ff  <= status_in;
         piggy_ff   <= piggy_in;
         msg_ff     <= msg_in;
         msg_cnt_ff <= msg_cnt_in;
         left_ff    <= left_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, left_ff, msg_cnt_ff, msg_ff, piggy_ff, status_ff};

endmodule
